// ===== hdl/circular_double_ended_queue_defines.svh =====
// Assertion macros shared by the deque RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 2'd0,
        K_PUSH_REAR  = 2'd1,
        K_POP_FRONT  = 2'd2,
        K_POP_REAR   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== hdl/cdq_req_if.sv =====
`default_nettype none

interface cdq_req_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_kind                     kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdq_rsp_if.sv =====
`default_nettype none

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] popped_value;
    t_status                   status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/circular_double_ended_queue.sv =====
// Double-ended queue over a ring of DEPTH 32-bit slots, of which the capacity
// register selects how many are used (0 acts as 1, above DEPTH acts as DEPTH).
// Each request item pushes or pops at either end and yields one response item
// with the popped word and a status (done, full, empty). A request is taken at
// its accept edge: pointer update, slot write and slot read all happen there
// in the slot memory (one write port, one read port), whose registered
// read data is the response payload in the next cycle. One item per cycle is
// sustained while the response side takes every item; the output register lets
// a new request in during the cycle its pending response is taken. Write
// capacity only while idle. The slot memory has no reset; popping a slot never
// written gives an undefined word.
`default_nettype none
`include "circular_double_ended_queue_defines.svh"

module circular_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [cdq_pkg::CAP_W-1:0] i_cfg_wdata,
    cdq_req_if.sink                        i_req,
    cdq_rsp_if.source                      o_rsp
);
    import cdq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic [CAP_W-1:0]   r_cap;
    logic [PW-1:0]      r_front, n_front;
    logic [PW-1:0]      r_rear, n_rear;
    logic [OW-1:0]      r_occ, n_occ;
    logic               r_out_valid;
    logic               r_pop_ok, n_pop_ok;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_rd_data;

    logic               acc;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic [PW-1:0]      rd_addr;
    logic [CW-1:0]      eff_cap;
    logic [CW-1:0]      cap_ext;
    logic               full;
    logic [PW-1:0]      fwd_front, fwd_rear, back_front, back_rear;
    logic [CW-1:0]      front_inc, rear_inc;
    logic [CW-1:0]      front_ext, rear_ext;
    logic [CW-1:0]      cap_dec;
    logic [OW-1:0]      occ_dec;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;

    always_comb begin
        cap_ext = CW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = cap_ext;
        end
        cap_dec    = eff_cap - CW'(1);
        front_ext  = CW'(r_front);
        rear_ext   = CW'(r_rear);
        front_inc  = front_ext + CW'(1);
        rear_inc   = rear_ext + CW'(1);
        fwd_front  = (front_inc >= eff_cap) ? '0 : front_inc[PW-1:0];
        fwd_rear   = (rear_inc >= eff_cap) ? '0 : rear_inc[PW-1:0];
        back_front = (r_front == '0 || front_ext >= eff_cap) ? cap_dec[PW-1:0]
                                                              : r_front - PW'(1);
        back_rear  = (r_rear == '0 || rear_ext >= eff_cap) ? cap_dec[PW-1:0]
                                                            : r_rear - PW'(1);
        full       = CW'(r_occ) >= eff_cap;
        occ_dec    = r_occ - OW'(1);
    end

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_occ    = r_occ;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_addr  = (i_req.kind == K_POP_FRONT) ? r_front : r_rear;
        n_pop_ok = 1'b0;
        n_status = ST_DONE;
        case (i_req.kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
                if (r_occ == '0) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_occ   = OW'(1);
                    wr_en   = 1'b1;
                end else if (full) begin
                    n_status = ST_FULL;
                end else if (i_req.kind == K_PUSH_FRONT) begin
                    n_front = back_front;
                    wr_addr = back_front;
                    wr_en   = 1'b1;
                    n_occ   = r_occ + OW'(1);
                end else begin
                    n_rear  = fwd_rear;
                    wr_addr = fwd_rear;
                    wr_en   = 1'b1;
                    n_occ   = r_occ + OW'(1);
                end
            end
            K_POP_FRONT, K_POP_REAR: begin
                if (r_occ == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_occ    = occ_dec;
                    if (occ_dec == '0) begin
                        n_front = '0;
                        n_rear  = '0;
                    end else if (i_req.kind == K_POP_FRONT) begin
                        n_front = fwd_front;
                    end else begin
                        n_rear = back_rear;
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            r_mem[wr_addr] <= i_req.value;
        end
        if (acc) begin
            r_rd_data <= r_mem[rd_addr];
            r_pop_ok  <= n_pop_ok;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_front     <= '0;
            r_rear      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (acc) begin
                r_front     <= n_front;
                r_rear      <= n_rear;
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_pop_ok ? r_rd_data : '0;

    `CDQ_ASSERT_NOW(a_empty_ends_home, i_clk, i_rst_n, r_occ == '0,
        (r_front == '0) && (r_rear == '0), "empty deque with ends off slot 0")
    `CDQ_ASSERT_NEXT(a_pop_empty_refused, i_clk, i_rst_n,
        acc && (i_req.kind == K_POP_FRONT || i_req.kind == K_POP_REAR) && r_occ == '0,
        o_rsp.valid && o_rsp.status == ST_EMPTY && $stable(r_occ),
        "pop from empty deque not refused")
    `CDQ_ASSERT_NEXT(a_push_full_refused, i_clk, i_rst_n,
        acc && (i_req.kind == K_PUSH_FRONT || i_req.kind == K_PUSH_REAR)
            && r_occ != '0 && full,
        o_rsp.valid && o_rsp.status == ST_FULL && $stable(r_occ)
            && $stable(r_front) && $stable(r_rear),
        "push into full deque changed state")

endmodule

`default_nettype wire

// ===== sim/tb_circular_double_ended_queue.sv =====
module tb_circular_double_ended_queue;
    import cdq_pkg::*;

    localparam int unsigned SLOT_COUNT  = 16;
    localparam int unsigned SLOT_IW     = 4;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_ITEMS = 136;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped;
        t_status                   status;
    } t_deque_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    cdq_req_if req_if();
    cdq_rsp_if rsp_if();

    circular_double_ended_queue #(
        .DEPTH(SLOT_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    logic [VALUE_W-1:0] ring_word [SLOT_COUNT];
    bit                 ring_word_set [SLOT_COUNT];
    int unsigned        front_at;
    int unsigned        rear_at;
    int unsigned        held_count;
    logic [CAP_W-1:0]   capacity_reg;

    t_deque_reply replies_due [$];
    int unsigned  mismatches;
    int unsigned  cycle_count;
    int unsigned  burst_left;

    logic [15:0]  accept_mask;
    logic [3:0]   mask_pos;
    int unsigned  mask_age;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned ring_size();
        if (capacity_reg < 1) begin
            return 1;
        end
        if (capacity_reg > SLOT_COUNT) begin
            return SLOT_COUNT;
        end
        return 32'(capacity_reg);
    endfunction

    function automatic int unsigned ring_next(input int unsigned p, input int unsigned cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_prev(input int unsigned p, input int unsigned cap);
        return (p == 0 || p >= cap) ? cap - 1 : p - 1;
    endfunction

    task automatic apply_deque_request(input t_kind k, input logic [VALUE_W-1:0] v);
        t_deque_reply r;
        int unsigned  cap;
        cap      = ring_size();
        r.popped = '0;
        r.status = ST_DONE;
        if (k == K_PUSH_FRONT || k == K_PUSH_REAR) begin
            if (held_count == 0) begin
                front_at         = 0;
                rear_at          = 0;
                ring_word[0]     = v;
                ring_word_set[0] = 1'b1;
                held_count       = 1;
            end else if (held_count >= cap) begin
                r.status = ST_FULL;
            end else if (k == K_PUSH_FRONT) begin
                front_at                          = ring_prev(front_at, cap);
                ring_word[SLOT_IW'(front_at)]     = v;
                ring_word_set[SLOT_IW'(front_at)] = 1'b1;
                held_count++;
            end else begin
                rear_at                          = ring_next(rear_at, cap);
                ring_word[SLOT_IW'(rear_at)]     = v;
                ring_word_set[SLOT_IW'(rear_at)] = 1'b1;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            if (k == K_POP_FRONT) begin
                r.popped = ring_word[SLOT_IW'(front_at)];
                held_count--;
                if (held_count != 0) begin
                    front_at = ring_next(front_at, cap);
                end
            end else begin
                r.popped = ring_word[SLOT_IW'(rear_at)];
                held_count--;
                if (held_count != 0) begin
                    rear_at = ring_prev(rear_at, cap);
                end
            end
            if (held_count == 0) begin
                front_at = 0;
                rear_at  = 0;
            end
        end
        replies_due.push_back(r);
    endtask

    // A pop must never read a slot that was never written.
    function automatic bit pop_hits_blank(input t_kind k);
        if (held_count == 0) begin
            return 1'b0;
        end
        if (k == K_POP_FRONT) begin
            return !ring_word_set[SLOT_IW'(front_at)];
        end
        if (k == K_POP_REAR) begin
            return !ring_word_set[SLOT_IW'(rear_at)];
        end
        return 1'b0;
    endfunction

    function automatic t_kind pick_kind(input int unsigned push_pct);
        t_kind k;
        if ($urandom_range(0, 99) < push_pct) begin
            k = $urandom_range(0, 1) ? K_PUSH_REAR : K_PUSH_FRONT;
        end else begin
            k = $urandom_range(0, 1) ? K_POP_REAR : K_POP_FRONT;
        end
        if (pop_hits_blank(k)) begin
            k = (k == K_POP_FRONT) ? K_PUSH_FRONT : K_PUSH_REAR;
        end
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch %s: got %h want %h, cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    // Called at a falling edge; leaves valid high while a burst goes on.
    task automatic send_request(input t_kind k, input logic [VALUE_W-1:0] v);
        int unsigned gap;
        req_if.valid <= 1'b1;
        req_if.kind  <= k;
        req_if.value <= v;
        do @(posedge i_clk); while (!req_if.ready);
        apply_deque_request(k, v);
        @(negedge i_clk);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_for_replies();
        if (req_if.valid) begin
            req_if.valid <= 1'b0;
        end
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg  = c;
        @(negedge i_clk);
    endtask

    task automatic test_empty_pops();
        send_request(K_POP_FRONT, 32'h1234_5678);
        send_request(K_POP_REAR, 32'hFFFF_FFFF);
        wait_for_replies();
    endtask

    task automatic test_extreme_words();
        send_request(K_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(K_PUSH_FRONT, 32'h8000_0000);
        send_request(K_POP_REAR, 32'h0);
        send_request(K_POP_FRONT, 32'h0);
        wait_for_replies();
    endtask

    task automatic test_full_refusal();
        write_capacity(5'd2);
        send_request(K_PUSH_REAR, 32'h0000_0000);
        send_request(K_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(K_PUSH_REAR, 32'h5555_AAAA);
        send_request(K_POP_FRONT, 32'h0);
        send_request(K_POP_REAR, 32'h0);
        wait_for_replies();
    endtask

    task automatic test_shrink_while_held();
        write_capacity(5'd16);
        send_request(K_PUSH_REAR, 32'h0000_0011);
        send_request(K_PUSH_REAR, 32'h0000_0022);
        send_request(K_PUSH_REAR, 32'h0000_0033);
        send_request(K_PUSH_REAR, 32'h0000_0044);
        wait_for_replies();
        write_capacity(5'd3);
        send_request(K_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(K_POP_REAR, 32'h0);
        send_request(K_PUSH_REAR, 32'hCAFE_F00D);
        send_request(K_POP_FRONT, 32'h0);
        send_request(K_PUSH_FRONT, 32'hA5A5_5A5A);
        send_request(K_POP_FRONT, 32'h0);
        send_request(K_POP_FRONT, 32'h0);
        send_request(K_POP_FRONT, 32'h0);
        wait_for_replies();
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] cap_plan [12];
        int unsigned      push_pct;
        int unsigned      span;
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd16, 5'd9,
                     5'd3, 5'd12, 5'd16};
        for (int ph = 0; ph < 12; ph++) begin
            wait_for_replies();
            write_capacity((ph >= 9) ? 5'($urandom_range(0, 31)) : cap_plan[ph]);
            push_pct = 80;
            span     = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (span == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 85;
                        1: push_pct = 20;
                        default: push_pct = 50;
                    endcase
                    span = 2 * ring_size() + $urandom_range(1, 6);
                end
                span--;
                send_request(pick_kind(push_pct), pick_word());
            end
        end
        wait_for_replies();
    endtask

    always @(negedge i_clk) begin
        mask_pos = mask_pos + 4'd1;
        mask_age++;
        if (mask_age == 80) begin
            mask_age = 0;
            case ($urandom_range(0, 3))
                0: accept_mask = 16'hFFFF;
                1: accept_mask = 16'($urandom | $urandom);
                2: accept_mask = 16'($urandom);
                default: accept_mask = 16'h0001 | 16'($urandom & $urandom);
            endcase
        end
        rsp_if.ready <= accept_mask[mask_pos];
    end

    always @(posedge i_clk) begin
        t_deque_reply want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected item", rsp_if.popped_value, '0);
            end else begin
                want = replies_due.pop_front();
                if (rsp_if.popped_value !== want.popped) begin
                    report_mismatch("popped_value", rsp_if.popped_value, want.popped);
                end
                if (rsp_if.status !== want.status) begin
                    report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        req_if.valid  = 1'b0;
        req_if.kind   = K_PUSH_FRONT;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        accept_mask   = 16'hFFFF;
        mask_pos      = '0;
        mask_age      = 0;
        front_at      = 0;
        rear_at       = 0;
        held_count    = 0;
        capacity_reg  = CAP_RESET;
        mismatches    = 0;
        cycle_count   = 0;
        burst_left    = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            ring_word[SLOT_IW'(i)]     = '0;
            ring_word_set[SLOT_IW'(i)] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_pops();
        test_extreme_words();
        test_full_refusal();
        test_shrink_while_held();
        test_random_traffic();

        wait_for_replies();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
